@@ rtl/core/lbpcs_pkg.sv @@
// Shared types and constants for the 3x3 LBP code stream unit.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package lbpcs_pkg;

    localparam int PIX_W        = 8;
    localparam int CODE_W       = 8;
    localparam int POS_OUT_W    = 11;
    localparam int CFG_W        = 12;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 32;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int MIN_SIZE       = 3;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // per-pixel position flags, worked out when the pixel is taken
    typedef struct packed {
        logic interior;
        logic last;
    } t_pos_flags;

    // stage one control from the top level to the window
    typedef struct packed {
        logic fire;
    } t_win_ctrl;

endpackage

`default_nettype wire

@@ rtl/core/lbp_3x3_code_stream_unit.sv @@
// 3x3 local binary pattern over a raster pixel stream: top level.
// Depends on lbpcs_pkg, lbpcs_geom, lbpcs_line_buf, lbpcs_window.
//
// Usage:
//   Slave stream: one pixel per beat, tdata[7:0] = pixel, tuser = frame
//   start (puts the position back to row 0, column 0 before the pixel).
//   Master stream: one beat per interior pixel, tdata = {col, row, code},
//   tlast marks the last interior pixel of the frame. Border pixels give
//   no beat.
//   Config channel: index 0 = image width, 1 = image height (12 bit,
//   clamped to 3..MAX); write only while no pixel is in flight.
// Timing:
//   One pixel per clock sustained while the receiver keeps up. A code is
//   computed in the cycle after its pixel is taken (line store read data
//   is registered) and shows on the master side once the working stage
//   retires it into the output register. Position counters and the window
//   sit in one loop that advances once per pixel.
//   When the receiver stalls, the working stage takes one more pixel if
//   it is empty, then tready drops until the output register is emptied.
// Reset:
//   Position, window and size registers return to 0 / 640 x 480; the
//   line stores are not cleared and need two rows to fill.
`default_nettype none

module lbp_3x3_code_stream_unit #(
    parameter int MAX_WIDTH  = lbpcs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbpcs_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // [7:0] pixel
    input  wire logic [lbpcs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] frame_start
    input  wire logic                                 i_s_axis_tuser,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // [7:0] lbp_code, [18:8] out_row, [29:19] out_col, [31:30] zero
    output logic [lbpcs_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    output logic                                      o_m_axis_tlast,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire lbpcs_pkg::t_cfg_idx                  i_cfg_index,
    input  wire logic [lbpcs_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                                 accept;
    logic                                 fire;
    lbpcs_pkg::t_win_ctrl                 win_ctrl;

    logic [CW-1:0]                        pos_col;
    lbpcs_pkg::t_pos_flags                pos_flags;
    logic [lbpcs_pkg::POS_OUT_W-1:0]      pos_out_row;
    logic [lbpcs_pkg::POS_OUT_W-1:0]      pos_out_col;

    // working stage
    logic                                 r_s1_valid;
    logic [CW-1:0]                        r_s1_col;
    logic [lbpcs_pkg::PIX_W-1:0]          r_s1_px;
    lbpcs_pkg::t_pos_flags                r_s1_flags;
    logic [lbpcs_pkg::POS_OUT_W-1:0]      r_s1_row_o;
    logic [lbpcs_pkg::POS_OUT_W-1:0]      r_s1_col_o;

    logic [lbpcs_pkg::PIX_W-1:0]          top_px;
    logic [lbpcs_pkg::PIX_W-1:0]          mid_px;
    logic [lbpcs_pkg::CODE_W-1:0]         code;

    // output register
    logic                                 r_out_valid;
    logic [lbpcs_pkg::CODE_W-1:0]         r_out_code;
    logic [lbpcs_pkg::POS_OUT_W-1:0]      r_out_row;
    logic [lbpcs_pkg::POS_OUT_W-1:0]      r_out_col;
    logic                                 r_out_last;

    assign fire            = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || fire;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign win_ctrl.fire   = fire;

    lbpcs_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geom (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_frame_start (i_s_axis_tuser),
        .o_col         (pos_col),
        .o_flags       (pos_flags),
        .o_out_row     (pos_out_row),
        .o_out_col     (pos_out_col)
    );

    lbpcs_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (pos_col),
        .i_wr_en   (fire),
        .i_wr_addr (r_s1_col),
        .i_px      (r_s1_px),
        .o_top     (top_px),
        .o_mid     (mid_px)
    );

    lbpcs_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (win_ctrl),
        .i_top   (top_px),
        .i_mid   (mid_px),
        .i_bot   (r_s1_px),
        .o_code  (code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col   <= pos_col;
            r_s1_px    <= i_s_axis_tdata[lbpcs_pkg::PIX_W-1:0];
            r_s1_flags <= pos_flags;
            r_s1_row_o <= pos_out_row;
            r_s1_col_o <= pos_out_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= r_s1_flags.interior;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_code <= code;
            r_out_row  <= r_s1_row_o;
            r_out_col  <= r_s1_col_o;
            r_out_last <= r_s1_flags.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_col, r_out_row, r_out_code};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // a border pixel leaving the working stage never leaves a beat behind
    a_border_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_s1_flags.interior |=> !r_out_valid)
        else $error("border pixel produced an output beat");

    // a taken pixel always lands in the working stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted pixel lost before working stage");

    // a held working stage keeps its column, so the line store write waits
    a_hold_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !fire |=> r_s1_valid && $stable(r_s1_col))
        else $error("working stage changed while held");

    // an unread result blocks the working stage
    a_out_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !fire)
        else $error("working stage retired over a pending result");
`endif

endmodule

`default_nettype wire

@@ rtl/core/lbpcs_geom.sv @@
// Size registers, size clamping and raster position counters.
// Depends on lbpcs_pkg.
`default_nettype none

module lbpcs_geom #(
    parameter int MAX_WIDTH  = lbpcs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbpcs_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire lbpcs_pkg::t_cfg_idx                i_cfg_index,
    input  wire logic [lbpcs_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                               i_accept,
    input  wire logic                               i_frame_start,
    output logic [$clog2(MAX_WIDTH)-1:0]            o_col,
    output lbpcs_pkg::t_pos_flags                   o_flags,
    output logic [lbpcs_pkg::POS_OUT_W-1:0]         o_out_row,
    output logic [lbpcs_pkg::POS_OUT_W-1:0]         o_out_col
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW = (lbpcs_pkg::CFG_W > WW) ?
                          ((lbpcs_pkg::CFG_W > HW) ? lbpcs_pkg::CFG_W : HW) :
                          ((WW > HW) ? WW : HW);

    logic [lbpcs_pkg::CFG_W-1:0] r_width_cfg;
    logic [lbpcs_pkg::CFG_W-1:0] r_height_cfg;
    logic [CW-1:0]               r_col;
    logic [RW-1:0]               r_row;
    logic [CW-1:0]               n_col;
    logic [RW-1:0]               n_row;

    logic [CMPW-1:0] width_ext;
    logic [CMPW-1:0] height_ext;
    logic [WW-1:0]   width_eff;
    logic [HW-1:0]   height_eff;
    logic [CW-1:0]   col_cur;
    logic [RW-1:0]   row_cur;
    logic [WW-1:0]   col_nxt;
    logic [HW-1:0]   row_nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= lbpcs_pkg::RST_IMAGE_WIDTH;
            r_height_cfg <= lbpcs_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbpcs_pkg::CFG_IMAGE_WIDTH:  r_width_cfg  <= i_cfg_data;
                lbpcs_pkg::CFG_IMAGE_HEIGHT: r_height_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp sizes to 3..MAX
    always_comb begin
        width_ext  = CMPW'(r_width_cfg);
        height_ext = CMPW'(r_height_cfg);
        if (width_ext < CMPW'(lbpcs_pkg::MIN_SIZE)) begin
            width_eff = WW'(lbpcs_pkg::MIN_SIZE);
        end else if (width_ext > CMPW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(width_ext);
        end
        if (height_ext < CMPW'(lbpcs_pkg::MIN_SIZE)) begin
            height_eff = HW'(lbpcs_pkg::MIN_SIZE);
        end else if (height_ext > CMPW'(MAX_HEIGHT)) begin
            height_eff = HW'(MAX_HEIGHT);
        end else begin
            height_eff = HW'(height_ext);
        end
    end

    always_comb begin
        col_cur = i_frame_start ? '0 : r_col;
        row_cur = i_frame_start ? '0 : r_row;
        col_nxt = WW'(col_cur) + WW'(1);
        row_nxt = HW'(row_cur) + HW'(1);
        if (col_nxt >= width_eff) begin
            n_col = '0;
            n_row = (row_nxt >= height_eff) ? '0 : RW'(row_nxt);
        end else begin
            n_col = CW'(col_nxt);
            n_row = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_col            = col_cur;
        o_flags.interior = (row_cur >= RW'(2)) && (col_cur >= CW'(2)) &&
                           (HW'(row_cur) < height_eff) && (WW'(col_cur) < width_eff);
        o_flags.last     = (HW'(row_cur) == height_eff - HW'(1)) &&
                           (WW'(col_cur) == width_eff - WW'(1));
        o_out_row        = lbpcs_pkg::POS_OUT_W'(row_cur - RW'(1));
        o_out_col        = lbpcs_pkg::POS_OUT_W'(col_cur - CW'(1));
    end

endmodule

`default_nettype wire

@@ rtl/core/lbpcs_line_buf.sv @@
// Two line stores (rows two above and one above) with registered read
// and forwarding from the write in flight. Depends on lbpcs_pkg.
`default_nettype none

module lbpcs_line_buf #(
    parameter int MAX_WIDTH = lbpcs_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]      i_rd_addr,
    input  wire logic                              i_wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]      i_wr_addr,
    input  wire logic [lbpcs_pkg::PIX_W-1:0]       i_px,
    output logic [lbpcs_pkg::PIX_W-1:0]            o_top,
    output logic [lbpcs_pkg::PIX_W-1:0]            o_mid
);

    logic [lbpcs_pkg::PIX_W-1:0] mem_upper  [MAX_WIDTH];
    logic [lbpcs_pkg::PIX_W-1:0] mem_middle [MAX_WIDTH];
    logic [lbpcs_pkg::PIX_W-1:0] r_top;
    logic [lbpcs_pkg::PIX_W-1:0] r_mid;

    // the pixel being retired shifts its column down one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_upper[i_wr_addr]  <= r_mid;
            mem_middle[i_wr_addr] <= i_px;
        end
    end

    // same column read and written on one edge only after a frame restart
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_rd_addr == i_wr_addr)) begin
                r_top <= r_mid;
                r_mid <= i_px;
            end else begin
                r_top <= mem_upper[i_rd_addr];
                r_mid <= mem_middle[i_rd_addr];
            end
        end
    end

    assign o_top = r_top;
    assign o_mid = r_mid;

endmodule

`default_nettype wire

@@ rtl/core/lbpcs_window.sv @@
// 3x3 window columns c-2, c-1 and the comparison into an LBP code.
// Depends on lbpcs_pkg.
`default_nettype none

module lbpcs_window (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lbpcs_pkg::t_win_ctrl           i_ctrl,
    input  wire logic [lbpcs_pkg::PIX_W-1:0]    i_top,
    input  wire logic [lbpcs_pkg::PIX_W-1:0]    i_mid,
    input  wire logic [lbpcs_pkg::PIX_W-1:0]    i_bot,
    output logic [lbpcs_pkg::CODE_W-1:0]        o_code
);

    // 0,1: top row c-2,c-1; 2,3: middle; 4,5: bottom
    logic [lbpcs_pkg::PIX_W-1:0] r_win [6];
    logic [lbpcs_pkg::PIX_W-1:0] center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_ctrl.fire) begin
            r_win[0] <= r_win[1];
            r_win[1] <= i_top;
            r_win[2] <= r_win[3];
            r_win[3] <= i_mid;
            r_win[4] <= r_win[5];
            r_win[5] <= i_bot;
        end
    end

    always_comb begin
        center    = r_win[3];
        o_code[7] = r_win[0] >= center;
        o_code[6] = r_win[1] >= center;
        o_code[5] = i_top    >= center;
        o_code[4] = i_mid    >= center;
        o_code[3] = i_bot    >= center;
        o_code[2] = r_win[5] >= center;
        o_code[1] = r_win[4] >= center;
        o_code[0] = r_win[2] >= center;
    end

endmodule

`default_nettype wire
